// File: src/ade_pkg.sv
// Shared types and constants for the exponential attack/decay envelope.
// Depends on nothing; ade_out_if, ade_step and the top level refer to it by scoped names.
package ade_pkg;

    localparam int LEVEL_W = 24;
    localparam int COEFF_W = 24;
    localparam int COUNT_W = 25;
    localparam int CFG_DATA_W = 24;
    localparam int CFG_IDX_W = 3;
    localparam int COEFF_FRAC = 22;

    // A start level of zero is replaced by roughly 0.001 in Q4.20.
    localparam logic [LEVEL_W-1:0] START_FLOOR = 24'd1049;
    localparam logic [LEVEL_W-1:0] LEVEL_MAX = 24'hFFFFFF;

    typedef logic [CFG_IDX_W-1:0] t_reg_idx;

    localparam t_reg_idx REG_INIT_LEVEL = 3'd0;
    localparam t_reg_idx REG_ATTACK_COEFF = 3'd1;
    localparam t_reg_idx REG_DECAY_COEFF = 3'd2;
    localparam t_reg_idx REG_ATTACK_SAMPLES = 3'd3;
    localparam t_reg_idx REG_DECAY_SAMPLES = 3'd4;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_ATTACK = 2'd1,
        PH_DECAY = 2'd2
    } t_phase;

    typedef struct packed {
        logic [LEVEL_W-1:0] init_level;
        logic signed [COEFF_W-1:0] attack_coeff;
        logic signed [COEFF_W-1:0] decay_coeff;
        logic [LEVEL_W-1:0] attack_samples;
        logic [LEVEL_W-1:0] decay_samples;
    } t_cfg;

    typedef struct packed {
        t_phase phase;
        logic [COUNT_W-1:0] count;
        logic [LEVEL_W-1:0] level;
        logic prev_gate;
        logic prev_trigger;
    } t_state;

endpackage

// File: src/ade_in_if.sv
// Input channel of the envelope: one item carries the gate and trigger flags.
// Stands alone; used by the top level.
interface ade_in_if;
    logic valid;
    logic ready;
    logic gate;
    logic trigger;

    modport source (output valid, output gate, output trigger, input ready);
    modport sink (input valid, input gate, input trigger, output ready);
endinterface

// File: src/ade_out_if.sv
// Output channel of the envelope: one item carries one level in Q4.20.
// Uses ade_pkg for the level width.
interface ade_out_if;
    logic valid;
    logic ready;
    logic [ade_pkg::LEVEL_W-1:0] level;

    modport source (output valid, output level, input ready);
    modport sink (input valid, input level, output ready);
endinterface

// File: src/ade_step.sv
// Next-state logic of the envelope for one sample: edge detect, phase update
// and the level scaling multiply. Uses the types and constants of ade_pkg.
module ade_step (
    input  ade_pkg::t_cfg   i_cfg,
    input  ade_pkg::t_state i_state,
    input  logic            i_gate,
    input  logic            i_trigger,
    output ade_pkg::t_state o_state,
    output logic            o_restart
);

    logic [ade_pkg::LEVEL_W-1:0]        w_base;
    ade_pkg::t_phase                    w_phase;
    logic [ade_pkg::COUNT_W-1:0]        w_count;
    logic [ade_pkg::COUNT_W-1:0]        w_count_inc;
    logic [ade_pkg::LEVEL_W-1:0]        w_lvl_in;
    logic signed [ade_pkg::COEFF_W-1:0] w_coeff;
    logic signed [48:0]                 w_prod;
    logic signed [26:0]                 w_delta;
    logic signed [27:0]                 w_sum;
    logic [ade_pkg::LEVEL_W-1:0]        w_scaled;

    assign w_base = (i_cfg.init_level != '0) ? i_cfg.init_level : ade_pkg::START_FLOOR;
    assign o_restart = (i_trigger & ~i_state.prev_trigger) | (i_gate & ~i_state.prev_gate);

    always_comb begin
        w_phase = i_state.phase;
        w_count = i_state.count;
        if (o_restart) begin
            if (i_cfg.attack_samples != '0) begin
                w_phase = ade_pkg::PH_ATTACK;
            end
            w_count = '0;
        end
    end

    assign w_count_inc = w_count + 1'b1;

    // Attack reloads the start level on its first sample before scaling.
    assign w_lvl_in = (w_phase == ade_pkg::PH_ATTACK && w_count == '0) ? w_base
                                                                        : i_state.level;
    assign w_coeff = (w_phase == ade_pkg::PH_ATTACK) ? i_cfg.attack_coeff : i_cfg.decay_coeff;

    // Rounding adds one half; the arithmetic shift then floors, so ties go upward.
    assign w_prod = $signed({1'b0, w_lvl_in}) * w_coeff + 49'sd2097152;
    assign w_delta = w_prod[48:ade_pkg::COEFF_FRAC];
    assign w_sum = $signed({4'b0000, w_lvl_in}) + $signed({w_delta[26], w_delta});

    always_comb begin
        if (w_sum[27]) begin
            w_scaled = '0;
        end else if (w_sum[26:24] != 3'b000) begin
            w_scaled = ade_pkg::LEVEL_MAX;
        end else begin
            w_scaled = w_sum[23:0];
        end
    end

    always_comb begin
        o_state.phase = w_phase;
        o_state.count = w_count;
        o_state.level = i_state.level;
        o_state.prev_gate = i_gate;
        o_state.prev_trigger = i_trigger;
        unique case (w_phase)
            ade_pkg::PH_IDLE: begin
                o_state.level = w_base;
            end
            ade_pkg::PH_ATTACK: begin
                o_state.count = w_count_inc;
                if (w_count_inc > {1'b0, i_cfg.attack_samples}) begin
                    o_state.phase = ade_pkg::PH_DECAY;
                    o_state.count = '0;
                    o_state.level = w_lvl_in;
                end else begin
                    o_state.level = w_scaled;
                end
            end
            ade_pkg::PH_DECAY: begin
                o_state.count = w_count_inc;
                if (w_count_inc > {1'b0, i_cfg.decay_samples}) begin
                    o_state.phase = ade_pkg::PH_IDLE;
                    o_state.count = '0;
                end else begin
                    o_state.level = w_scaled;
                end
            end
            default: begin
                o_state.level = '0;
            end
        endcase
    end

endmodule

// File: src/exponential_ad_envelope.sv
// Top level of the exponential attack/decay envelope: configuration registers,
// input stage, state registers and output register. Uses ade_pkg, ade_step and both channels.
//
//  port        dir    carries
//  i_sample    sink   item of gate and trigger flags
//  o_level     source item of one envelope level, Q4.20
//  i_cfg_*     in     register write: enable, index, 24-bit data
//
// One item a cycle while the output is not stalled: an accepted item is held in the input stage,
// and its level is loaded into the output register when the step advances, and is then offered.
// The envelope state and the single 25 x 24 multiply update once per item in that step.
// A stalled output holds the input stage, which then holds the input channel.
// Synchronous active-low reset clears the configuration, the envelope state and both valids.
module exponential_ad_envelope (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    ade_in_if.sink                        i_sample,
    ade_out_if.source                     o_level,
    input  logic                          i_cfg_we,
    input  ade_pkg::t_reg_idx             i_cfg_idx,
    input  logic [ade_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    ade_pkg::t_cfg   r_cfg;
    ade_pkg::t_state r_state;
    ade_pkg::t_state n_state;
    logic            r_in_valid;
    logic            r_in_gate;
    logic            r_in_trigger;
    logic            r_out_valid;
    logic [ade_pkg::LEVEL_W-1:0] r_out_level;
    logic            w_adv;
    logic            w_restart;

    assign w_adv = r_in_valid && (!r_out_valid || o_level.ready);
    assign i_sample.ready = !r_in_valid || w_adv;
    assign o_level.valid = r_out_valid;
    assign o_level.level = r_out_level;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                ade_pkg::REG_INIT_LEVEL:     r_cfg.init_level <= i_cfg_data;
                ade_pkg::REG_ATTACK_COEFF:   r_cfg.attack_coeff <= $signed(i_cfg_data);
                ade_pkg::REG_DECAY_COEFF:    r_cfg.decay_coeff <= $signed(i_cfg_data);
                ade_pkg::REG_ATTACK_SAMPLES: r_cfg.attack_samples <= i_cfg_data;
                ade_pkg::REG_DECAY_SAMPLES:  r_cfg.decay_samples <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    ade_step u_step (
        .i_cfg     (r_cfg),
        .i_state   (r_state),
        .i_gate    (r_in_gate),
        .i_trigger (r_in_trigger),
        .o_state   (n_state),
        .o_restart (w_restart)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_out_valid <= 1'b0;
            r_state <= '{phase: ade_pkg::PH_IDLE, default: '0};
        end else begin
            if (i_sample.ready) begin
                r_in_valid <= i_sample.valid;
            end
            if (w_adv) begin
                r_out_valid <= 1'b1;
                r_state <= n_state;
            end else if (o_level.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_sample.ready && i_sample.valid) begin
            r_in_gate <= i_sample.gate;
            r_in_trigger <= i_sample.trigger;
        end
        if (w_adv) begin
            r_out_level <= n_state.level;
        end
    end

`ifndef ASSERT_OFF
    // The counter is only ever left non-zero inside attack or decay.
    a_idle_count_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.phase == ade_pkg::PH_IDLE |-> r_state.count == '0)
        else $error("sample count non-zero while idle");

    // A flag edge with attack enabled always lands in attack.
    a_restart_attack: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_adv && w_restart && r_cfg.attack_samples != '0 |=>
        r_state.phase == ade_pkg::PH_ATTACK && r_state.count == 1)
        else $error("restart did not enter attack");

    // A held input stage keeps its item until the output side frees up.
    a_stage_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !w_adv |=> r_in_valid && $stable(r_in_gate) && $stable(r_in_trigger))
        else $error("input stage dropped a stalled item");

    // A new result only appears after the step has advanced.
    a_out_from_adv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(w_adv))
        else $error("result appeared without a step");
`endif

endmodule
